FILE: rtl/core/zhang_suen_thinning_pass_assert.svh
// Assertion macros for the thinning pass.
`ifndef ZHANG_SUEN_THINNING_PASS_ASSERT_SVH
`define ZHANG_SUEN_THINNING_PASS_ASSERT_SVH

// Check cons in the same cycle as ante.
`define ZST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zst check failed");

// Check cons in the cycle after ante.
`define ZST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zst check failed");

`endif

FILE: rtl/core/zst_pkg.sv
`timescale 1ns / 1ps
package zst_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;
  localparam int OUT_W  = 10;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_PASS     = 2'd2;

  typedef struct packed {
    logic pixel_bit;
    logic frame_start;
  } pix_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
    logic             new_value;
    logic             was_deleted;
  } res_t;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic              sub_pass;
  } cfg_t;

  // One interior pixel waiting for judgment: window plus its coordinates.
  typedef struct packed {
    logic [8:0]       window;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
  } win_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: rtl/core/zhang_suen_thinning_pass.sv
`timescale 1ns / 1ps
`include "zhang_suen_thinning_pass_assert.svh"
// One Zhang-Suen thinning sub-iteration over a 1-bit raster stream. The block
// takes one pixel per clock while pix_stall is low, and reports each interior
// pixel once its 3x3 window is complete, i.e. while the pixel one row and one
// column later arrives; border pixels give no beat. The rate is set by the line
// buffer, a single 2-bit-wide memory of MAX_WIDTH entries read and written once
// per clock; a read that meets the write still in flight is forwarded. A pixel
// passes through the stage-1 registers and the queue into the output register,
// and the four-entry queue lets the output side stall without stopping input
// at once. Line buffer contents are not cleared at reset: the first two rows
// of each frame fill them before any result depends on them. Sizes are
// clamped to [3, MAX]; write configuration only while the block is idle.
module zhang_suen_thinning_pass (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  zst_pkg::pix_t                     pix,
  output logic                              res_valid,
  input  logic                              res_stall,
  output zst_pkg::res_t                     res,
  input  logic                              cfg_write,
  input  logic [zst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [zst_pkg::SIZE_W-1:0]        cfg_data
);
  import zst_pkg::*;

  cfg_t         cfg;
  fifo_status_t q_status;
  win_item_t    q_item, q_head;
  logic         q_push, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= SIZE_W'(MAX_WIDTH);
      cfg.frame_height <= SIZE_W'(MAX_HEIGHT);
      cfg.sub_pass     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        REG_SUB_PASS:     cfg.sub_pass     <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  zst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  zst_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  zst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  `ZST_ASSERT_NOW(a_no_push_full, q_push, !q_status.full)
  `ZST_ASSERT_NOW(a_no_pop_empty, q_pop, !q_status.empty)
  `ZST_ASSERT_NOW(a_interior_only, res_valid, (res.out_row != '0) && (res.out_col != '0))
  `ZST_ASSERT_NEXT(a_full_stalls, q_status.full && !q_pop && pix_valid && !pix_stall,
                   !q_status.empty)

endmodule

FILE: rtl/core/zst_front.sv
`timescale 1ns / 1ps
module zst_front (
  input  logic                     clk,
  input  logic                     rst,
  input  zst_pkg::cfg_t            cfg,
  input  logic                     pix_valid,
  output logic                     pix_stall,
  input  zst_pkg::pix_t            pix,
  input  zst_pkg::fifo_status_t    q_status,
  output logic                     q_push,
  output zst_pkg::win_item_t       q_item
);
  import zst_pkg::*;

  // Line buffer entry: bit 1 = row r-2, bit 0 = row r-1.
  logic [1:0] line_mem [MAX_WIDTH];

  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [8:0]        window;

  logic              s1_valid;
  logic              s1_pix;
  logic              s1_interior;
  logic [ROW_W-1:0]  s1_r;
  logic [COL_W-1:0]  s1_c;
  logic [1:0]        rd;
  logic              fwd;
  logic [1:0]        fdata;

  logic [SIZE_W-1:0] w_lim, h_lim;
  logic [COL_W-1:0]  c_cur, col_count_next;
  logic [ROW_W-1:0]  r_cur, row_count_next;
  logic [SIZE_W-1:0] c_inc, r_inc;
  logic              accept, s1_go;
  logic              up_eff, mid_eff;
  logic [8:0]        window_next;

  always_comb begin
    if (cfg.frame_width < SIZE_W'(3)) begin
      w_lim = SIZE_W'(3);
    end else if (cfg.frame_width > SIZE_W'(MAX_WIDTH)) begin
      w_lim = SIZE_W'(MAX_WIDTH);
    end else begin
      w_lim = cfg.frame_width;
    end
    if (cfg.frame_height < SIZE_W'(3)) begin
      h_lim = SIZE_W'(3);
    end else if (cfg.frame_height > SIZE_W'(MAX_HEIGHT)) begin
      h_lim = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_lim = cfg.frame_height;
    end

    c_cur = pix.frame_start ? '0 : col_count;
    r_cur = pix.frame_start ? '0 : row_count;
    if (SIZE_W'(c_cur) >= w_lim) c_cur = '0;
    if (SIZE_W'(r_cur) >= h_lim) r_cur = '0;

    c_inc = SIZE_W'(c_cur) + SIZE_W'(1);
    r_inc = SIZE_W'(r_cur) + SIZE_W'(1);
    if (c_inc >= w_lim) begin
      col_count_next = '0;
      row_count_next = (r_inc >= h_lim) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_count_next = c_inc[COL_W-1:0];
      row_count_next = r_cur;
    end
  end

  assign s1_go     = s1_valid && (!s1_interior || !q_status.full);
  assign pix_stall = s1_valid && !s1_go;
  assign accept    = pix_valid && !pix_stall;

  // Take the column from the write still in flight when it hits the same entry.
  assign up_eff      = fwd ? fdata[1] : rd[1];
  assign mid_eff     = fwd ? fdata[0] : rd[0];
  assign window_next = {window[5:0], up_eff, mid_eff, s1_pix};

  assign q_push      = s1_go && s1_interior;
  assign q_item.window = window_next;
  assign q_item.row    = OUT_W'(s1_r - ROW_W'(1));
  assign q_item.col    = OUT_W'(s1_c - COL_W'(1));

  always_ff @(posedge clk) begin
    if (s1_go) line_mem[s1_c] <= {mid_eff, s1_pix};
    if (accept) rd <= line_mem[c_cur];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pix.pixel_bit;
      s1_r        <= r_cur;
      s1_c        <= c_cur;
      s1_interior <= (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
      fwd         <= s1_go && (s1_c == c_cur);
      fdata       <= {mid_eff, s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      col_count <= '0;
      row_count <= '0;
      window    <= '0;
    end else begin
      if (accept) begin
        s1_valid  <= 1'b1;
        col_count <= col_count_next;
        row_count <= row_count_next;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) window <= window_next;
    end
  end

endmodule

FILE: rtl/core/zst_fifo.sv
`timescale 1ns / 1ps
module zst_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  zst_pkg::win_item_t    push_item,
  input  logic                  pop,
  output zst_pkg::win_item_t    head,
  output zst_pkg::fifo_status_t status
);
  import zst_pkg::*;

  win_item_t        slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign status.full  = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/zst_back.sv
`timescale 1ns / 1ps
module zst_back (
  input  logic                  clk,
  input  logic                  rst,
  input  zst_pkg::cfg_t         cfg,
  input  zst_pkg::fifo_status_t q_status,
  input  zst_pkg::win_item_t    q_head,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output zst_pkg::res_t         res
);
  import zst_pkg::*;

  logic       p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [7:0] trans, ring;
  logic [3:0] a_cnt, b_cnt;
  logic       m1, m2, mark, del;
  logic       load;

  always_comb begin
    p1 = q_head.window[4];
    p2 = q_head.window[5];
    p3 = q_head.window[2];
    p4 = q_head.window[1];
    p5 = q_head.window[0];
    p6 = q_head.window[3];
    p7 = q_head.window[6];
    p8 = q_head.window[7];
    p9 = q_head.window[8];
    ring  = {p2, p3, p4, p5, p6, p7, p8, p9};
    trans = {~p2 & p3, ~p3 & p4, ~p4 & p5, ~p5 & p6,
             ~p6 & p7, ~p7 & p8, ~p8 & p9, ~p9 & p2};
    a_cnt = 4'($countones(trans));
    b_cnt = 4'($countones(ring));
    m1 = cfg.sub_pass ? (p2 & p4 & p8) : (p2 & p4 & p6);
    m2 = cfg.sub_pass ? (p2 & p6 & p8) : (p4 & p6 & p8);
    mark = (a_cnt == 4'd1) && (b_cnt >= 4'd2) && (b_cnt <= 4'd6) && !m1 && !m2;
    del  = p1 & mark;
  end

  // Refill the output register whenever it is empty or its beat leaves.
  assign load  = !res_valid || !res_stall;
  assign q_pop = load && !q_status.empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.out_row     <= q_head.row;
      res.out_col     <= q_head.col;
      res.new_value   <= p1 & ~del;
      res.was_deleted <= del;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= q_pop;
    end
  end

endmodule
